// ===== design/ffpea_pkg.sv =====
// Shared types and constants for the first-fit page extent allocator.
`default_nettype none
package ffpea_pkg;
  localparam int OFF_W = 10;
  localparam int PG_W = 11;
  localparam int SIZE_W = 23;
  localparam int CMD_W = 2;
  localparam int ST_W = 3;
  localparam int MAX_PAGES = 1024;
  localparam int DEF_PAGE_SHIFT = 12;
  localparam int DEF_MAX_EXTENTS = 64;
  localparam int RESET_TOTAL_PAGES = 1024;

  localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO = 3'd1;
  localparam logic [ST_W-1:0] ST_NOSPACE = 3'd2;
  localparam logic [ST_W-1:0] ST_INVALID = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFF_W-1:0]  region_offset;
    logic [PG_W-1:0]   region_pages;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] granted_offset;
    logic [PG_W-1:0]  granted_pages;
    logic [PG_W-1:0]  pages_free;
  } rsp_t;

  typedef struct packed {
    logic [OFF_W-1:0] start;
    logic [PG_W-1:0]  len;
  } ext_t;
endpackage
`default_nettype wire

// ===== design/ffpea_cell.sv =====
// One slot of the extent ring: holds an extent and passes it to its neighbor.
`default_nettype none
module ffpea_cell import ffpea_pkg::*; (
  input  logic clk,
  input  logic shift_en,
  input  logic load_en,
  input  ext_t shift_in,
  input  ext_t load_val,
  output ext_t ext
);
  always_ff @(posedge clk) begin
    if (load_en) begin
      ext <= load_val;
    end else if (shift_en) begin
      ext <= shift_in;
    end
  end
endmodule
`default_nettype wire

// ===== design/first_fit_page_extent_allocator_top.sv =====
// Top level of the first-fit page extent allocator with its extent ring and sequencer.
`default_nettype none
// Commands are taken when start is high and busy is low; each command gives one result
// on result, marked by a one-cycle done pulse that the receiver cannot stall. Init,
// zero-size requests and requests rejected up front finish in the cycle after they are
// taken. Allocate and free rotate the extent ring once to scan it, take a decision step,
// then rotate it once more while rewriting it; the command ends at the decision step
// instead when the scan rejects it. In both rotations one entry leaves the ring's head
// per cycle.
module first_fit_page_extent_allocator_top import ffpea_pkg::*; #(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  req_t            request,
  output logic            busy,
  output logic            done,
  output rsp_t            result,
  input  logic            cfg_we,
  input  logic [PG_W-1:0] cfg_wdata
);
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam int PC_W = SIZE_W - PAGE_SHIFT + 1;
  localparam int CMP_W = (PC_W > PG_W) ? PC_W : PG_W;
  localparam logic [CNT_W-1:0] N_EXT = CNT_W'(MAX_EXTENTS);
  localparam logic [CNT_W-1:0] N_LAST = CNT_W'(MAX_EXTENTS - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_MOD    = 4'b1000
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt, used, fit_idx, ins_idx;
  logic [PG_W-1:0] total_pages, free_total;
  logic [CMD_W-1:0] op;
  logic [PC_W-1:0] pc;
  logic [OFF_W-1:0] off, fit_start;
  logic [PG_W-1:0] pages, fit_len, prev_end, next_len;
  logic [OFF_W-1:0] next_start;
  logic fit_found, has_prev, has_next, prev_adj, next_adj;
  ext_t q [2];
  logic [1:0] qn;

  ext_t ring [MAX_EXTENTS];
  ext_t tail, head, load_val, p0, p1, q0_next, q1_next;
  ext_t lst [4];
  logic shift, load0, accept, slot_ok, pop;
  logic [1:0] pv, n, qn_next;
  logic [PG_W-1:0] seg, free_end;
  logic [SIZE_W:0] sz_round;
  logic [PC_W-1:0] pc_in;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign head = ring[0];
  assign seg = (total_pages > PG_W'(MAX_PAGES)) ? PG_W'(MAX_PAGES) : total_pages;
  assign sz_round = {1'b0, request.size_bytes} + (SIZE_W + 1)'((1 << PAGE_SHIFT) - 1);
  assign pc_in = PC_W'(sz_round >> PAGE_SHIFT);
  assign free_end = PG_W'({1'b0, off} + pages);
  assign shift = (state == S_SCAN) || (state == S_MOD);
  assign load0 = accept && (request.command == CMD_INIT) && (seg != '0);
  assign load_val = '{start: '0, len: seg};
  assign slot_ok = (cnt < used);

  genvar k;
  generate
    for (k = 0; k < MAX_EXTENTS; k++) begin : g_cell
      if (k == MAX_EXTENTS - 1) begin : g_last
        ffpea_cell u_cell (.clk(clk), .shift_en(shift), .load_en(1'b0),
          .shift_in(tail), .load_val(load_val), .ext(ring[k]));
      end else if (k == 0) begin : g_first
        ffpea_cell u_cell (.clk(clk), .shift_en(shift), .load_en(load0),
          .shift_in(ring[k+1]), .load_val(load_val), .ext(ring[k]));
      end else begin : g_mid
        ffpea_cell u_cell (.clk(clk), .shift_en(shift), .load_en(1'b0),
          .shift_in(ring[k+1]), .load_val(load_val), .ext(ring[k]));
      end
    end
  endgenerate

  // rewrite pass: entries produced from the head slot
  always_comb begin
    p0 = head;
    p1 = head;
    pv = 2'd0;
    if (state == S_MOD && cnt < N_EXT) begin
      if (op == CMD_ALLOC) begin
        if (slot_ok) begin
          if (cnt == fit_idx) begin
            if (head.len != PG_W'(pc)) begin
              p0.start = OFF_W'(head.start + OFF_W'(pc));
              p0.len = PG_W'(head.len - PG_W'(pc));
              pv = 2'd1;
            end
          end else begin
            pv = 2'd1;
          end
        end
      end else begin
        if (!prev_adj && !next_adj && cnt == ins_idx) begin
          p0.start = off;
          p0.len = pages;
          pv = slot_ok ? 2'd2 : 2'd1;
        end else if (slot_ok) begin
          if (prev_adj && CNT_W'(cnt + 1'b1) == ins_idx) begin
            p0.len = PG_W'(head.len + pages + (next_adj ? next_len : '0));
            pv = 2'd1;
          end else if (next_adj && cnt == ins_idx) begin
            if (!prev_adj) begin
              p0.start = off;
              p0.len = PG_W'(head.len + pages);
              pv = 2'd1;
            end
          end else begin
            pv = 2'd1;
          end
        end
      end
    end
  end

  // pending queue: holds entries until their slot comes around
  always_comb begin
    lst[0] = q[0];
    lst[1] = q[1];
    lst[2] = p0;
    lst[3] = p1;
    if (qn == 2'd0) begin
      lst[0] = p0;
      lst[1] = p1;
    end else if (qn == 2'd1) begin
      lst[1] = p0;
      lst[2] = p1;
    end
    n = qn + pv;
    pop = (state == S_MOD) && (cnt != '0);
    if (pop) begin
      q0_next = lst[1];
      q1_next = lst[2];
      qn_next = (n == 2'd0) ? 2'd0 : n - 2'd1;
    end else begin
      q0_next = lst[0];
      q1_next = lst[1];
      qn_next = n;
    end
    tail = (state == S_SCAN) ? head : lst[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      free_total <= '0;
      total_pages <= PG_W'(RESET_TOTAL_PAGES);
      done <= 1'b0;
      qn <= 2'd0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        total_pages <= cfg_wdata;
      end
      q[0] <= q0_next;
      q[1] <= q1_next;
      qn <= qn_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= request.command;
            pc <= pc_in;
            off <= request.region_offset;
            pages <= request.region_pages;
            fit_found <= 1'b0;
            has_prev <= 1'b0;
            has_next <= 1'b0;
            ins_idx <= used;
            cnt <= '0;
            qn <= 2'd0;
            result <= '{status: ST_INVALID, granted_offset: '0, granted_pages: '0,
                        pages_free: free_total};
            unique case (request.command)
              CMD_INIT: begin
                used <= (seg != '0) ? CNT_W'(1) : '0;
                free_total <= seg;
                result.status <= ST_OK;
                result.pages_free <= seg;
                done <= 1'b1;
              end
              CMD_ALLOC: begin
                if (request.size_bytes == '0) begin
                  result.status <= ST_ZERO;
                  done <= 1'b1;
                end else if (CMP_W'(pc_in) > CMP_W'(free_total)) begin
                  result.status <= ST_NOSPACE;
                  done <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_FREE: begin
                if (request.region_pages == '0) begin
                  result.status <= ST_ZERO;
                  done <= 1'b1;
                end else if (PG_W'(request.region_offset) >= seg ||
                             request.region_pages > PG_W'(seg - PG_W'(request.region_offset))) begin
                  done <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (slot_ok) begin
            if (op == CMD_ALLOC) begin
              if (!fit_found && CMP_W'(head.len) >= CMP_W'(pc)) begin
                fit_found <= 1'b1;
                fit_idx <= cnt;
                fit_start <= head.start;
                fit_len <= head.len;
              end
            end else if (head.start < off) begin
              has_prev <= 1'b1;
              prev_end <= PG_W'(head.start + head.len);
            end else if (!has_next) begin
              has_next <= 1'b1;
              ins_idx <= cnt;
              next_start <= head.start;
              next_len <= head.len;
            end
          end
          cnt <= CNT_W'(cnt + 1'b1);
          if (cnt == N_LAST) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          cnt <= '0;
          state <= S_MOD;
          if (op == CMD_ALLOC) begin
            if (!fit_found) begin
              result.status <= ST_NOSPACE;
              done <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            prev_adj <= has_prev && (prev_end == PG_W'(off));
            next_adj <= has_next && (PG_W'(next_start) == free_end);
            if ((has_prev && prev_end > PG_W'(off)) ||
                (has_next && free_end > PG_W'(next_start))) begin
              result.status <= ST_INVALID;
              done <= 1'b1;
              state <= S_IDLE;
            end else if (!(has_prev && prev_end == PG_W'(off)) &&
                         !(has_next && PG_W'(next_start) == free_end) &&
                         used >= N_EXT) begin
              result.status <= ST_FULL;
              done <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_MOD: begin
          cnt <= CNT_W'(cnt + 1'b1);
          if (cnt == N_EXT) begin
            state <= S_IDLE;
            done <= 1'b1;
            result.status <= ST_OK;
            if (op == CMD_ALLOC) begin
              if (fit_len == PG_W'(pc)) begin
                used <= CNT_W'(used - 1'b1);
              end
              free_total <= PG_W'(free_total - PG_W'(pc));
              result.pages_free <= PG_W'(free_total - PG_W'(pc));
              result.granted_offset <= fit_start;
              result.granted_pages <= PG_W'(pc);
            end else begin
              if (prev_adj && next_adj) begin
                used <= CNT_W'(used - 1'b1);
              end else if (!prev_adj && !next_adj) begin
                used <= CNT_W'(used + 1'b1);
              end
              free_total <= PG_W'(free_total + pages);
              result.pages_free <= PG_W'(free_total + pages);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst) used <= N_EXT)
    else $error("extent count exceeds table depth");
  a_queue_bound: assert property (@(posedge clk) disable iff (rst) qn <= 2'd2)
    else $error("pending queue overflow");
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.granted_pages != '0 |-> result.status == ST_OK)
    else $error("pages granted on a failed transfer");
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy || done)
    else $error("accepted command neither busy nor done");
endmodule
`default_nettype wire
